/* design/prc_pkg.sv */
// Package for the polygon rectangle clipper: shared constants, codes and types.
// No dependencies; prc_front, prc_back, the top level and both test files import it.
package prc_pkg;

  // default sizing for the top-level parameters
  localparam int MAX_VERTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_AX = 2'd0,
    REG_AY = 2'd1,
    REG_BX = 2'd2,
    REG_BY = 2'd3
  } reg_idx_t;

  // clip edge codes, in pass order
  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_RIGHT  = 2'd2,
    SIDE_TOP    = 2'd3
  } side_t;

  // control part of the queue head seen by the back end
  typedef struct packed {
    logic valid;
    logic last;
    logic drop;
  } q_ctrl_t;

endpackage

/* design/prc_if.sv */
// Valid/ready channel interfaces for vertex input and clipped vertex output.
// Depends on nothing; widths come from the COORD_BITS parameter.
interface prc_vtx_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         vertex_last;
  modport source  (output valid, vertex_x, vertex_y, vertex_last, input ready);
  modport sink    (input valid, vertex_x, vertex_y, vertex_last, output ready);
  modport monitor (input valid, vertex_x, vertex_y, vertex_last, ready);
endinterface

interface prc_res_if #(parameter int COORD_BITS = 12);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_last;
  logic                         out_empty;
  logic                         out_overflow;
  modport source (output valid, out_x, out_y, out_last, out_empty, out_overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_last, out_empty, out_overflow, output ready);
  modport monitor (input valid, out_x, out_y, out_last, out_empty, out_overflow, ready);
endinterface

/* design/prc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prc_ram #(
  parameter int W = 24,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/prc_front.sv */
// Front end: takes vertex transfers, marks the ones beyond the buffer limit
// as dropped and queues them for the back end. Depends on prc_pkg, prc_if.
module prc_front #(
  parameter int MAX_VERTS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  prc_vtx_if.sink                      in_vtx,
  output prc_pkg::q_ctrl_t             q_ctrl,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  input  logic                         q_pop
);
  import prc_pkg::*;

  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  logic signed [COORD_BITS-1:0] qx_r [QDEPTH];
  logic signed [COORD_BITS-1:0] qy_r [QDEPTH];
  logic                         ql_r [QDEPTH];
  logic                         qd_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] n_r;
  logic [CW-1:0] fcnt_r;
  logic          push;
  logic          full;

  assign full         = (n_r == NW'(QDEPTH));
  assign in_vtx.ready = !full;
  assign push         = in_vtx.valid && !full;

  // queue head
  assign q_ctrl.valid = (n_r != '0);
  assign q_ctrl.last  = ql_r[rp_r];
  assign q_ctrl.drop  = qd_r[rp_r];
  assign q_x          = qx_r[rp_r];
  assign q_y          = qy_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qx_r[wp_r] <= in_vtx.vertex_x;
      qy_r[wp_r] <= in_vtx.vertex_y;
      ql_r[wp_r] <= in_vtx.vertex_last;
      qd_r[wp_r] <= (fcnt_r == CW'(MAX_VERTS));
    end
  end

  // pointers, fill level and per-polygon vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      n_r    <= '0;
      fcnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
        if (in_vtx.vertex_last) begin
          fcnt_r <= '0;
        end else if (fcnt_r != CW'(MAX_VERTS)) begin
          fcnt_r <= fcnt_r + 1'b1;
        end
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !q_pop) begin
        n_r <= n_r + 1'b1;
      end else if (!push && q_pop) begin
        n_r <= n_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_level: assert property (@(posedge clk) disable iff (!rst_n) n_r <= NW'(QDEPTH))
    else $error("queue level beyond depth");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> n_r != '0)
    else $error("pop from empty queue");
`endif
endmodule

/* design/prc_back.sv */
// Back end: buffers a polygon, runs the four clip passes between two RAMs
// with a shared multiply and bit-serial divider, then streams the result.
// Depends on prc_pkg, prc_if, prc_ram.
module prc_back #(
  parameter int MAX_VERTS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prc_pkg::q_ctrl_t             q_ctrl,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output logic                         q_pop,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  prc_res_if.source                    out_res
);
  import prc_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int AW = $clog2(MAX_VERTS);
  localparam int NB = 2 * C + 2;
  localparam int KW = $clog2(NB + 1);

  typedef enum logic [13:0] {
    S_LOAD   = 14'h0001,
    S_RD_S   = 14'h0002,
    S_WT_S   = 14'h0004,
    S_RD_P   = 14'h0008,
    S_WT_P   = 14'h0010,
    S_MUL    = 14'h0020,
    S_ABS    = 14'h0040,
    S_DIV    = 14'h0080,
    S_FIX    = 14'h0100,
    S_EMIT_C = 14'h0200,
    S_EMIT_P = 14'h0400,
    S_NEXT   = 14'h0800,
    S_PEND   = 14'h1000,
    S_OUT    = 14'h2000
  } st_t;

  st_t  state_r;
  logic out_ld_r;   // second half of an output read (data valid this cycle)
  logic empty_go_r; // pending empty result

  logic signed [C-1:0] xl_r, xr_r, yb_r, yt_r;
  logic signed [C-1:0] sx_r, sy_r, px_r, py_r, cx_r, cy_r;
  side_t               side_r;
  logic                src_r, ovf_r, inp_r;
  logic [CW-1:0]       lcnt_r, ncnt_r, jcnt_r, dcnt_r, kcnt_r;
  logic signed [NB-1:0] num_r;
  logic signed [C:0]    d_r;
  logic [NB-1:0]        nq_r;
  logic [C:0]           dmag_r, rem_r;
  logic                 neg_r;
  logic [KW-1:0]        div_cnt_r;

  logic                         ov_r, ol_r, oe_r, oo_r;
  logic signed [C-1:0]          ox_r, oy_r;

  // RAM ports
  logic          we0, we1, re;
  logic [AW-1:0] waddr, raddr;
  logic [2*C-1:0] wdata, rd0, rd1, rdat;

  prc_ram #(.W(2*C), .D(MAX_VERTS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rd0));
  prc_ram #(.W(2*C), .D(MAX_VERTS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rd1));

  assign rdat = src_r ? rd1 : rd0;

  // window bounds from corners
  logic signed [C-1:0] wxl, wxr, wyb, wyt;
  assign wxl = (ax < bx) ? ax : bx;
  assign wxr = (ax < bx) ? bx : ax;
  assign wyb = (ay < by) ? ay : by;
  assign wyt = (ay < by) ? by : ay;

  // per-side bound and coordinate selection
  logic                bx_side;
  logic signed [C-1:0] bnd, s_c, s_o, p_c, p_o, r_x, r_y, r_c;
  logic                in_s, in_p;
  always_comb begin
    bx_side = (side_r == SIDE_LEFT) || (side_r == SIDE_RIGHT);
    case (side_r)
      SIDE_LEFT:   bnd = xl_r;
      SIDE_BOTTOM: bnd = yb_r;
      SIDE_RIGHT:  bnd = xr_r;
      default:     bnd = yt_r;
    endcase
    s_c = bx_side ? sx_r : sy_r;
    s_o = bx_side ? sy_r : sx_r;
    p_c = bx_side ? px_r : py_r;
    p_o = bx_side ? py_r : px_r;
    r_x = rdat[2*C-1:C];
    r_y = rdat[C-1:0];
    r_c = bx_side ? r_x : r_y;
    if ((side_r == SIDE_LEFT) || (side_r == SIDE_BOTTOM)) begin
      in_s = (s_c >= bnd);
      in_p = (r_c >= bnd);
    end else begin
      in_s = (s_c <= bnd);
      in_p = (r_c <= bnd);
    end
  end

  // crossing arithmetic
  logic signed [C:0]    dc, dov, dd;
  logic [C+1:0]         trial;
  logic                 tbit;
  logic signed [NB-1:0] qs;
  logic [C-1:0]         o_new;
  always_comb begin
    dc    = {bnd[C-1], bnd} - {s_c[C-1], s_c};
    dov   = {p_o[C-1], p_o} - {s_o[C-1], s_o};
    dd    = {p_c[C-1], p_c} - {s_c[C-1], s_c};
    trial = {rem_r, nq_r[NB-1]};
    tbit  = (trial >= {1'b0, dmag_r});
    qs    = neg_r ? -$signed(nq_r) : $signed(nq_r);
    o_new = (dmag_r == '0) ? s_o : s_o + qs[C-1:0];
  end

  logic fit;
  logic emit;
  logic out_free;
  logic ov_set;
  assign fit      = (dcnt_r != CW'(MAX_VERTS));
  assign emit     = (state_r == S_EMIT_C) || (state_r == S_EMIT_P);
  assign out_free = !ov_r || out_res.ready;
  assign q_pop    = (state_r == S_LOAD) && q_ctrl.valid && !empty_go_r;
  // output register takes a new result this cycle
  assign ov_set   = ((state_r == S_LOAD) && empty_go_r && out_free) ||
                    ((state_r == S_OUT) && out_ld_r);

  // RAM control
  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    re    = 1'b0;
    waddr = dcnt_r[AW-1:0];
    raddr = jcnt_r[AW-1:0];
    wdata = (state_r == S_EMIT_C) ? {cx_r, cy_r} : {px_r, py_r};
    if (state_r == S_LOAD) begin
      we0   = q_pop && !q_ctrl.drop;
      waddr = lcnt_r[AW-1:0];
      wdata = {q_x, q_y};
    end else if (emit && fit) begin
      we0 = src_r;
      we1 = !src_r;
    end
    case (state_r)
      S_RD_S: begin
        re    = 1'b1;
        raddr = AW'(ncnt_r - 1'b1);
      end
      S_RD_P: re = 1'b1;
      S_OUT: begin
        re    = !out_ld_r && out_free;
        raddr = kcnt_r[AW-1:0];
      end
      default: re = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      out_ld_r   <= 1'b0;
      empty_go_r <= 1'b0;
      lcnt_r     <= '0;
      jcnt_r     <= '0;
      dcnt_r     <= '0;
      ovf_r      <= 1'b0;
      src_r      <= 1'b0;
      div_cnt_r  <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (ov_set) begin
        ov_r <= 1'b1;
      end else if (out_res.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (empty_go_r) begin
            if (out_free) begin
              ox_r       <= '0;
              oy_r       <= '0;
              ol_r       <= 1'b1;
              oe_r       <= 1'b1;
              oo_r       <= ovf_r;
              ovf_r      <= 1'b0;
              empty_go_r <= 1'b0;
            end
          end else if (q_pop) begin
            if (q_ctrl.drop) begin
              ovf_r <= 1'b1;
            end else if (!q_ctrl.last) begin
              lcnt_r <= lcnt_r + 1'b1;
            end
            if (q_ctrl.last) begin
              ncnt_r <= lcnt_r + CW'(!q_ctrl.drop);
              lcnt_r <= '0;
              xl_r   <= wxl;
              xr_r   <= wxr;
              yb_r   <= wyb;
              yt_r   <= wyt;
              src_r  <= 1'b0;
              side_r <= SIDE_LEFT;
              if ((wxl == wxr) || (wyb == wyt)) begin
                empty_go_r <= 1'b1;
              end else begin
                state_r <= S_RD_S;
              end
            end
          end
        end
        S_RD_S: begin
          jcnt_r  <= '0;
          dcnt_r  <= '0;
          state_r <= S_WT_S;
        end
        S_WT_S: begin
          sx_r    <= rdat[2*C-1:C];
          sy_r    <= rdat[C-1:0];
          state_r <= S_RD_P;
        end
        S_RD_P: state_r <= S_WT_P;
        S_WT_P: begin
          px_r  <= rdat[2*C-1:C];
          py_r  <= rdat[C-1:0];
          inp_r <= in_p;
          if (in_p != in_s) begin
            state_r <= S_MUL;
          end else if (in_p) begin
            state_r <= S_EMIT_P;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL: begin
          num_r   <= dc * dov;
          d_r     <= dd;
          state_r <= S_ABS;
        end
        S_ABS: begin
          nq_r      <= num_r[NB-1] ? NB'(-num_r) : NB'(num_r);
          dmag_r    <= d_r[C] ? (C+1)'(-d_r) : (C+1)'(d_r);
          neg_r     <= num_r[NB-1] ^ d_r[C];
          rem_r     <= '0;
          div_cnt_r <= KW'(NB);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= tbit ? (C+1)'(trial - {1'b0, dmag_r}) : trial[C:0];
          nq_r      <= {nq_r[NB-2:0], tbit};
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == KW'(1)) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          cx_r    <= bx_side ? bnd : o_new;
          cy_r    <= bx_side ? o_new : bnd;
          state_r <= S_EMIT_C;
        end
        S_EMIT_C, S_EMIT_P: begin
          if (fit) begin
            dcnt_r <= dcnt_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= ((state_r == S_EMIT_C) && inp_r) ? S_EMIT_P : S_NEXT;
        end
        S_NEXT: begin
          sx_r    <= px_r;
          sy_r    <= py_r;
          jcnt_r  <= jcnt_r + 1'b1;
          state_r <= (jcnt_r + 1'b1 == ncnt_r) ? S_PEND : S_RD_P;
        end
        S_PEND: begin
          src_r  <= !src_r;
          ncnt_r <= dcnt_r;
          kcnt_r <= '0;
          if (dcnt_r == '0) begin
            empty_go_r <= 1'b1;
            state_r    <= S_LOAD;
          end else if (side_r == SIDE_TOP) begin
            state_r <= S_OUT;
          end else begin
            side_r  <= side_t'(side_r + 2'd1);
            state_r <= S_RD_S;
          end
        end
        S_OUT: begin
          if (out_ld_r) begin
            out_ld_r <= 1'b0;
            ox_r     <= rdat[2*C-1:C];
            oy_r     <= rdat[C-1:0];
            ol_r     <= (kcnt_r + 1'b1 == ncnt_r);
            oe_r     <= 1'b0;
            oo_r     <= ovf_r;
            kcnt_r   <= kcnt_r + 1'b1;
            if (kcnt_r + 1'b1 == ncnt_r) begin
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end
          end else if (out_free) begin
            out_ld_r <= 1'b1;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // output register
  assign out_res.valid        = ov_r;
  assign out_res.out_x        = ox_r;
  assign out_res.out_y        = oy_r;
  assign out_res.out_last     = ol_r;
  assign out_res.out_empty    = oe_r;
  assign out_res.out_overflow = oo_r;

`ifndef NO_ASSERTIONS
  a_dcnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> dcnt_r <= CW'(MAX_VERTS))
    else $error("pass count beyond buffer size");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r != '0 |-> state_r == S_DIV)
    else $error("divider busy outside divide state");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_LOAD) && !empty_go_r)
    else $error("queue popped while clipping");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld_r |-> !ov_r)
    else $error("output register overwritten");
`endif
endmodule

/* design/polygon_rect_clipper_unit.sv */
// Top level of the polygon rectangle clipper: window registers on the APB
// port, front end, queue and clipping back end. Depends on prc_pkg, prc_if,
// prc_front, prc_back.
//
//  channel  dir  handshake         payload
//  in_vtx   in   valid/ready       vertex_x, vertex_y, vertex_last
//  out_res  out  valid/ready       out_x, out_y, out_last, out_empty, out_overflow
//  cfg_*    in   psel/penable      corner_a_x/y, corner_b_x/y at 0x0,0x4,0x8,0xC
//
// Vertices enter at one per cycle into a four-entry queue while it has room;
// the back end then runs the four passes over the polygon, using a bit-serial
// divider for each edge crossing, and streams the results through the output
// register; it takes no new vertex from the queue until the polygon is out.
// Reset is synchronous, active low; the buffers need no clearing. Either side
// may stall without loss.
module polygon_rect_clipper_unit #(
  parameter int MAX_VERTS  = prc_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  prc_vtx_if.sink     in_vtx,
  prc_res_if.source   out_res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import prc_pkg::*;

  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r, rsel;
  reg_idx_t                     idx;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  // window corner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_AX:  ax_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_AY:  ay_r <= cfg_pwdata[COORD_BITS-1:0];
        REG_BX:  bx_r <= cfg_pwdata[COORD_BITS-1:0];
        default: by_r <= cfg_pwdata[COORD_BITS-1:0];
      endcase
    end
  end

  // register readback, sign extended
  always_comb begin
    case (idx)
      REG_AX:  rsel = ax_r;
      REG_AY:  rsel = ay_r;
      REG_BX:  rsel = bx_r;
      default: rsel = by_r;
    endcase
    cfg_prdata = 32'(rsel);
  end

  q_ctrl_t                      q_ctrl;
  logic signed [COORD_BITS-1:0] q_x, q_y;
  logic                         q_pop;

  prc_front #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_vtx(in_vtx),
    .q_ctrl(q_ctrl), .q_x(q_x), .q_y(q_y), .q_pop(q_pop));

  prc_back #(.MAX_VERTS(MAX_VERTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_ctrl(q_ctrl), .q_x(q_x), .q_y(q_y), .q_pop(q_pop),
    .ax(ax_r), .ay(ay_r), .bx(bx_r), .by(by_r),
    .out_res(out_res));
endmodule

/* test/polygon_clip_checker.sv */
// Checker for the polygon rectangle clipper: watches both vertex channels,
// predicts clipped polygons and compares each result transfer. Uses prc_pkg, prc_if.
module polygon_clip_checker #(
  parameter int MAX_VERTS  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  prc_vtx_if.monitor  vin,
  prc_res_if.monitor  vout,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count
);
  import prc_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   empty;
    logic   ovf;
  } clip_res_t;

  longint poly_x[$], poly_y[$];
  longint work_x[$], work_y[$];
  bit     dropped;
  clip_res_t clipped_q[$];
  longint win_ax, win_ay, win_bx, win_by;

  assign pending_count = clipped_q.size();

  function automatic bit on_inside(longint px, longint py, side_t sd, longint b);
    case (sd)
      SIDE_LEFT:   return px >= b;
      SIDE_BOTTOM: return py >= b;
      SIDE_RIGHT:  return px <= b;
      default:     return py <= b;
    endcase
  endfunction

  // crossing point on edge s->p; division truncates toward zero
  task automatic edge_cross(input longint sx, sy, px, py, input side_t sd,
                            input longint b, output longint cx, cy);
    longint d;
    if (sd == SIDE_LEFT || sd == SIDE_RIGHT) begin
      d = px - sx;
      cx = b;
      cy = (d != 0) ? sy + (b - sx) * (py - sy) / d : sy;
    end else begin
      d = py - sy;
      cy = b;
      cx = (d != 0) ? sx + (b - sy) * (px - sx) / d : sx;
    end
  endtask

  task automatic keep_vertex(input longint x, y, inout longint nx[$], ny[$]);
    if (nx.size() < MAX_VERTS) begin
      nx = {nx, x};
      ny = {ny, y};
    end else begin
      dropped = 1;
    end
  endtask

  task automatic clip_polygon();
    longint xl, xr, yb, yt, b, sx, sy, cx, cy;
    longint nx[$], ny[$];
    clip_res_t r;
    xl = (win_ax < win_bx) ? win_ax : win_bx;
    xr = (win_ax < win_bx) ? win_bx : win_ax;
    yb = (win_ay < win_by) ? win_ay : win_by;
    yt = (win_ay < win_by) ? win_by : win_ay;
    work_x = poly_x;
    work_y = poly_y;
    if (xl == xr || yb == yt) begin
      work_x.delete();
      work_y.delete();
    end else begin
      for (int s = 0; s < 4 && work_x.size() != 0; s++) begin
        b = (s == 0) ? xl : (s == 1) ? yb : (s == 2) ? xr : yt;
        nx.delete();
        ny.delete();
        sx = work_x[$];
        sy = work_y[$];
        foreach (work_x[j]) begin
          if (on_inside(work_x[j], work_y[j], side_t'(s), b)) begin
            if (!on_inside(sx, sy, side_t'(s), b)) begin
              edge_cross(sx, sy, work_x[j], work_y[j], side_t'(s), b, cx, cy);
              keep_vertex(cx, cy, nx, ny);
            end
            keep_vertex(work_x[j], work_y[j], nx, ny);
          end else if (on_inside(sx, sy, side_t'(s), b)) begin
            edge_cross(sx, sy, work_x[j], work_y[j], side_t'(s), b, cx, cy);
            keep_vertex(cx, cy, nx, ny);
          end
          sx = work_x[j];
          sy = work_y[j];
        end
        work_x = nx;
        work_y = ny;
      end
    end
    if (work_x.size() == 0) begin
      r = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, ovf: dropped};
      clipped_q = {clipped_q, r};
    end else begin
      foreach (work_x[k]) begin
        r.x = coord_t'(work_x[k]);
        r.y = coord_t'(work_y[k]);
        r.last = (k == work_x.size() - 1);
        r.empty = 0;
        r.ovf = dropped;
        clipped_q = {clipped_q, r};
      end
    end
    dropped = 0;
    poly_x.delete();
    poly_y.delete();
  endtask

  always @(posedge clk) begin
    clip_res_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
      poly_x.delete();
      poly_y.delete();
      clipped_q.delete();
      dropped = 0;
      win_ax = 0; win_ay = 0; win_bx = 0; win_by = 0;
    end else begin
      // window register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_AX: win_ax = coord_t'(cfg_pwdata[COORD_BITS-1:0]);
          REG_AY: win_ay = coord_t'(cfg_pwdata[COORD_BITS-1:0]);
          REG_BX: win_bx = coord_t'(cfg_pwdata[COORD_BITS-1:0]);
          default: win_by = coord_t'(cfg_pwdata[COORD_BITS-1:0]);
        endcase
      end
      // vertex transfer in
      if (vin.valid && vin.ready) begin
        if (poly_x.size() < MAX_VERTS) begin
          poly_x = {poly_x, longint'(vin.vertex_x)};
          poly_y = {poly_y, longint'(vin.vertex_y)};
        end else begin
          dropped = 1;
        end
        if (vin.vertex_last) clip_polygon();
      end
      // result transfer out
      if (vout.valid && vout.ready) begin
        got = '{x: vout.out_x, y: vout.out_y, last: vout.out_last,
                empty: vout.out_empty, ovf: vout.out_overflow};
        if (clipped_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = clipped_q.pop_front();
          // coordinates are don't-care on an empty result
          if (want.empty) begin
            got.x = '0;
            got.y = '0;
          end
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* test/polygon_rect_clipper_unit_test.sv */
// Testbench top for the polygon rectangle clipper: clock, reset, window
// setup over APB, vertex stimulus and verdict. Uses polygon_clip_checker.
module polygon_rect_clipper_unit_test;
  import prc_pkg::*;

  localparam int MAXV  = 64;
  localparam int CBITS = 12;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending_count;
  int          cycle_count = 0;
  int          vertex_total = 0;

  prc_vtx_if #(.COORD_BITS(CBITS)) vtx_ch ();
  prc_res_if #(.COORD_BITS(CBITS)) res_ch ();

  polygon_rect_clipper_unit #(.MAX_VERTS(MAXV), .COORD_BITS(CBITS)) DUT (
    .clk, .rst_n, .in_vtx(vtx_ch.sink), .out_res(res_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  polygon_clip_checker #(.MAX_VERTS(MAXV), .COORD_BITS(CBITS)) checker_i (
    .clk, .rst_n, .vin(vtx_ch.monitor), .vout(res_ch.monitor),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending_count
  );

  always #2 clk = ~clk;

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall before each transfer, sometimes none
  initial begin
    int wait_n;
    res_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (wait_n != 0) begin
        res_ch.ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      res_ch.ready <= 1;
      @(posedge clk iff res_ch.valid);
    end
  end

  // one register write: setup cycle, then access cycle; select stays up
  task automatic write_window(input reg_idx_t idx, input int value);
    cfg_psel   <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr  <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk iff cfg_pready);
  endtask

  task automatic set_window(input int ax, ay, bx, by);
    write_window(REG_AX, ax);
    write_window(REG_AY, ay);
    write_window(REG_BX, bx);
    write_window(REG_BY, by);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // one vertex transfer, with a random gap unless burst; valid stays high back to back
  task automatic send_vertex(input int x, y, input bit last, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      vtx_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    vtx_ch.valid <= 1;
    vtx_ch.vertex_x <= CBITS'(x);
    vtx_ch.vertex_y <= CBITS'(y);
    vtx_ch.vertex_last <= last;
    @(posedge clk iff vtx_ch.ready);
    vertex_total++;
  endtask

  task automatic end_vertices();
    vtx_ch.valid <= 0;
    vtx_ch.vertex_last <= 0;
  endtask

  // quiesce before a window change: all results in, then the back end tail
  task automatic drain();
    end_vertices();
    @(posedge clk iff pending_count == 0);
    repeat (600) @(posedge clk);
  endtask

  function automatic int rand_coord(input int lo, hi);
    return $urandom_range(0, hi - lo) + lo;
  endfunction

  task automatic random_polygon(input int n, input int span, input bit burst);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(-span, span - 1), rand_coord(-span, span - 1),
                  i == n - 1, burst);
  endtask

  initial begin
    int n, span;
    bit burst;
    vtx_ch.valid = 0;
    vtx_ch.vertex_x = '0;
    vtx_ch.vertex_y = '0;
    vtx_ch.vertex_last = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset window is degenerate: single empty result
    send_vertex(5, 5, 1, 0);
    drain();
    // swapped corners, square window
    set_window(100, 100, -100, -100);
    // fully inside
    send_vertex(0, 0, 0, 0); send_vertex(50, 0, 0, 0); send_vertex(0, 50, 1, 0);
    // triangle crossing all four sides, field extremes
    send_vertex(-2048, -2048, 0, 1); send_vertex(2047, -2048, 0, 1);
    send_vertex(0, 2047, 1, 1);
    // fully outside: nothing left
    send_vertex(500, 500, 0, 0); send_vertex(600, 500, 0, 0); send_vertex(600, 600, 1, 0);
    // single point and vertical edge on the boundary
    send_vertex(-100, 40, 1, 0);
    send_vertex(-150, -150, 0, 0); send_vertex(-150, 150, 0, 0); send_vertex(150, 0, 1, 0);
    // buffer overflow on input, last vertex dropped
    for (int i = 0; i < MAXV + 3; i++)
      send_vertex(rand_coord(-90, 90), rand_coord(-90, 90), i == MAXV + 2, 1);
    drain();
    // zero height window
    set_window(-2048, 7, 2047, 7);
    send_vertex(0, 0, 0, 0); send_vertex(10, 20, 0, 0); send_vertex(-5, 30, 1, 0);
    drain();
    // full range window; pass output overflow via many crossings
    set_window(-2048, 2047, 2047, -2048);
    random_polygon(5, 2048, 0);
    drain();
    set_window(-3, -3, 3, 3);
    for (int i = 0; i < MAXV; i++)
      send_vertex((i % 2) ? 1500 : -1500, (i % 4 < 2) ? -4 + i / 8 : 4 - i / 8,
                  i == MAXV - 1, 1);

    // random phases with varied windows
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_window(rand_coord(-2048, 2047), rand_coord(-2048, 2047),
                 rand_coord(-300, 300), rand_coord(-300, 300));
      for (int p = 0; p < 7; p++) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
        span = ($urandom_range(0, 1) == 0) ? 2048 : 400;
        burst = ($urandom_range(0, 3) == 0);
        random_polygon(n, span, burst);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
